// File: rtl/dsu_pkg.sv
package dsu_pkg;

  localparam int FIELD_W          = 10;
  localparam int NUM_ELEMENTS_DEF = 1024;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic rd;
    logic walk_adv;
    logic walk_end;
    logic comp_wr;
    logic save_ra;
    logic finish;
  } dsu_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rd_is_root;
    logic at_root;
    logic act_find;
  } dsu_sts_t;

endpackage

// File: rtl/dsu_ram.sv
module dsu_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/dsu_ctrl.sv
module dsu_ctrl
  import dsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dsu_sts_t sts,
  output dsu_cmd_t cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_W_RD = 3'd2;
  localparam logic [2:0] S_W_CK = 3'd3;
  localparam logic [2:0] S_C_RD = 3'd4;
  localparam logic [2:0] S_C_CK = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       pass_r, pass_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_busy;

  assign out_busy = out_valid_r && out_stall;

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    cmd       = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          pass_nxt  = 1'b0;
          state_nxt = S_W_RD;
        end
      end
      S_W_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_W_CK;
      end
      S_W_CK: begin
        if (sts.rd_is_root) begin
          cmd.walk_end = 1'b1;
          state_nxt    = S_C_RD;
        end else begin
          cmd.walk_adv = 1'b1;
          state_nxt    = S_W_RD;
        end
      end
      S_C_RD: begin
        if (!sts.at_root) begin
          cmd.rd    = 1'b1;
          state_nxt = S_C_CK;
        end else if (sts.act_find || pass_r) begin
          state_nxt = S_FIN;
        end else begin
          cmd.save_ra = 1'b1;
          pass_nxt    = 1'b1;
          state_nxt   = S_W_RD;
        end
      end
      S_C_CK: begin
        cmd.comp_wr = 1'b1;
        state_nxt   = S_C_RD;
      end
      S_FIN: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  assign out_valid_nxt = cmd.finish || out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/dsu_dp.sv
module dsu_dp
  import dsu_pkg::*;
#(
  parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_action,
  input  logic [FIELD_W-1:0] in_first_element,
  input  logic [FIELD_W-1:0] in_second_element,
  output logic [FIELD_W-1:0] out_root,
  output logic               out_merged,
  input  dsu_cmd_t           cmd,
  output dsu_sts_t           sts
);

  localparam int IW = $clog2(NUM_ELEMENTS);
  localparam int CW = ((IW > FIELD_W) ? IW : FIELD_W) + 1;

  logic [IW-1:0]      clr_cnt_r;
  logic [IW-1:0]      cur_r;
  logic [IW-1:0]      start_r;
  logic [IW-1:0]      root_r;
  logic [IW-1:0]      ra_r;
  logic [IW-1:0]      b_r;
  logic               act_r;
  logic [FIELD_W-1:0] out_root_r;
  logic               out_merged_r;

  logic [IW-1:0]      rd_data;
  logic               we;
  logic [IW-1:0]      waddr;
  logic [IW-1:0]      wdata;
  logic [IW-1:0]      a_cl;
  logic [IW-1:0]      b_cl;
  logic               differ;
  logic [IW-1:0]      lo_root;
  logic [IW-1:0]      hi_root;
  logic [CW-1:0]      res_ext;

  function automatic logic [IW-1:0] clamp_idx(input logic [FIELD_W-1:0] v);
    logic [CW-1:0] ext;
    ext = CW'(v);
    if (ext >= CW'(NUM_ELEMENTS)) begin
      return IW'(NUM_ELEMENTS - 1);
    end
    return ext[IW-1:0];
  endfunction

  assign a_cl    = clamp_idx(in_first_element);
  assign b_cl    = clamp_idx(in_second_element);
  assign differ  = (ra_r != root_r);
  assign lo_root = (ra_r < root_r) ? ra_r : root_r;
  assign hi_root = (ra_r < root_r) ? root_r : ra_r;

  always_comb begin
    we    = 1'b0;
    waddr = cur_r;
    wdata = root_r;
    if (cmd.clr_wr) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = clr_cnt_r;
    end else if (cmd.comp_wr) begin
      we = 1'b1;
    end else if (cmd.finish && !act_r && differ) begin
      we    = 1'b1;
      waddr = hi_root;
      wdata = lo_root;
    end
  end

  dsu_ram #(
    .WIDTH(IW),
    .DEPTH(NUM_ELEMENTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd),
    .raddr(cur_r),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_action;
      cur_r   <= a_cl;
      start_r <= a_cl;
      b_r     <= b_cl;
    end else if (cmd.walk_adv || cmd.comp_wr) begin
      cur_r <= rd_data;
    end else if (cmd.walk_end) begin
      root_r <= cur_r;
      cur_r  <= start_r;
    end else if (cmd.save_ra) begin
      ra_r    <= root_r;
      cur_r   <= b_r;
      start_r <= b_r;
    end
  end

  assign res_ext = CW'(act_r ? root_r : lo_root);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_root_r   <= res_ext[FIELD_W-1:0];
      out_merged_r <= !act_r && differ;
    end
  end

  assign sts.clr_last   = (clr_cnt_r == IW'(NUM_ELEMENTS - 1));
  assign sts.rd_is_root = (rd_data == cur_r);
  assign sts.at_root    = (cur_r == root_r);
  assign sts.act_find   = act_r;

  assign out_root   = out_root_r;
  assign out_merged = out_merged_r;

endmodule

// File: rtl/disjoint_set_union_find_top.sv
// Channel  Direction  Handshake            Fields
// in       input      in_valid / in_stall  in_action, in_first_element, in_second_element
// out      output     out_valid/out_stall  out_root, out_merged
//
// A find walks the parent links from the first element to its root, then walks the path
// again and writes the root into each entry on it; a union does the same for the second
// element, and where the roots differ the higher root is linked under the lower one as
// the result register is loaded. In the walk each link takes a read state and a check
// state, in the rewrite a read state and a write state, as the parent RAM has a single
// read port and a registered read. After reset a clearing pass writes every entry with
// its own index while in_stall stays high; a finished item waits in the output register
// while the next item is accepted.
module disjoint_set_union_find_top
  import dsu_pkg::*;
#(
  parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [FIELD_W-1:0] in_first_element,
  input  logic [FIELD_W-1:0] in_second_element,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] out_root,
  output logic               out_merged
);

  dsu_cmd_t cmd;
  dsu_sts_t sts;

  dsu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsu_dp #(
    .NUM_ELEMENTS(NUM_ELEMENTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_action        (in_action),
    .in_first_element (in_first_element),
    .in_second_element(in_second_element),
    .out_root         (out_root),
    .out_merged       (out_merged),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
